FILE: hw/rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants for the positional list insert block.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

  // list sizing
  localparam int CAPACITY = 32;
  localparam int ADDR_W   = 5;   // bits to address CAPACITY entries
  localparam int CNT_W    = 6;   // bits to hold a count of 0..CAPACITY
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;

  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_FWD,
    S_REV
  } ctrl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch position and value, start shift at the tail
    logic reject;    // emit a single rejection item
    logic shift_rd;  // read the entry below the shift index
    logic shift_wr;  // write it one place up, step index down
    logic insert;    // write the new value, bump the count
    logic fwd_rd;    // read for the head-to-tail listing
    logic rev_rd;    // read for the tail-to-head listing
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic reject;     // the offered item would be rejected
    logic shift_more; // entries remain above the insert position
    logic fwd_end;    // index sits on the tail
    logic rev_end;    // index sits on the head
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl
// Sequencer for shift, insert and the two listing passes.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_ctrl
  import pli_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          busy
);

  ctrl_state_t state_r, state_nxt;

  // hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // decide next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (stat.reject) begin
            cmd.reject = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = S_SHIFT_RD;
          end
        end
      end
      S_SHIFT_RD: begin
        if (stat.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_FWD;
      end
      S_FWD: begin
        cmd.fwd_rd = 1'b1;
        if (stat.fwd_end) begin
          state_nxt = S_REV;
        end
      end
      S_REV: begin
        cmd.rev_rd = 1'b1;
        if (stat.rev_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

FILE: hw/rtl/pli_dpath.sv
// ----------------------------------------------------------------------------
// pli_dpath
// List store, count, index counter and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_dpath
  import pli_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [POS_W-1:0]  in_position,
  input  wire logic [DATA_W-1:0] in_value,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  output logic                   out_strobe,
  output logic [1:0]             out_status,
  output logic                   out_direction,
  output logic [DATA_W-1:0]      out_element,
  output logic                   out_last
);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  idx_r;
  logic [CNT_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;

  logic              emit_valid_r;
  status_t           emit_status_r;
  logic              emit_dir_r;
  logic              emit_last_r;

  logic [CNT_W-1:0]  idx_below;
  logic [CNT_W-1:0]  tail_idx;
  logic [CNT_W:0]    in_pos_ext;
  logic              bad_pos;
  status_t           rej_code;
  logic              mem_rd;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_wr;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  assign idx_below = idx_r - CNT_W'(1);
  assign tail_idx  = count_r - CNT_W'(1);

  // check the offered item against the current count
  assign in_pos_ext = {1'b0, in_position[CNT_W-1:0]};
  assign bad_pos    = in_position[POS_W-1] || (in_pos_ext > {1'b0, count_r});
  assign rej_code   = bad_pos ? ST_BADPOS : ST_FULL;

  assign stat.reject     = bad_pos || (count_r >= CAP_COUNT);
  assign stat.shift_more = (idx_r > pos_r);
  assign stat.fwd_end    = (idx_r == tail_idx);
  assign stat.rev_end    = (idx_r == '0);

  // select memory ports
  assign mem_rd  = cmd.shift_rd || cmd.fwd_rd || cmd.rev_rd;
  assign rd_addr = cmd.shift_rd ? idx_below[ADDR_W-1:0] : idx_r[ADDR_W-1:0];
  assign mem_wr  = cmd.shift_wr || cmd.insert;
  assign wr_addr = cmd.insert ? pos_r[ADDR_W-1:0] : idx_r[ADDR_W-1:0];
  assign wr_data = cmd.insert ? val_r : rd_data_r;

  // list store
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // latch the item and step the index
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_r <= in_position[CNT_W-1:0];
      val_r <= in_value;
      idx_r <= count_r;
    end else if (cmd.shift_wr) begin
      idx_r <= idx_below;
    end else if (cmd.insert) begin
      idx_r <= '0;
    end else if (cmd.fwd_rd) begin
      if (!stat.fwd_end) begin
        idx_r <= idx_r + CNT_W'(1);
      end
    end else if (cmd.rev_rd) begin
      if (!stat.rev_end) begin
        idx_r <= idx_below;
      end
    end
  end

  // count the elements
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.insert) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // track result controls alongside the registered read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_valid_r <= 1'b0;
    end else begin
      emit_valid_r <= cmd.reject || cmd.fwd_rd || cmd.rev_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reject) begin
      emit_status_r <= rej_code;
      emit_dir_r    <= 1'b0;
      emit_last_r   <= 1'b1;
    end else if (cmd.fwd_rd || cmd.rev_rd) begin
      emit_status_r <= ST_OK;
      emit_dir_r    <= cmd.rev_rd;
      emit_last_r   <= cmd.rev_rd && stat.rev_end;
    end
  end

  // drive the result ports; rejections carry a zero element
  assign out_strobe    = emit_valid_r;
  assign out_status    = emit_status_r;
  assign out_direction = emit_dir_r;
  assign out_element   = (emit_status_r == ST_OK) ? rd_data_r : '0;
  assign out_last      = emit_last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/positional_list_insert_dump.sv
// ----------------------------------------------------------------------------
// positional_list_insert_dump
// Ordered list of signed words with insert-at-position and full listing.
// ----------------------------------------------------------------------------
// Usage:
//   Offer an item on in_position / in_value with start; it is taken at a
//   rising edge where start is high and busy is low. A valid item shifts
//   the entries above the position up by one (a read and a write state per
//   moved entry, one memory port each for read and write), writes the value,
//   then lists the whole list head to tail and tail to head, one item a cycle.
//   Each result sits on the out_ ports for one cycle, flagged by
//   out_strobe; the receiver cannot stall it. out_last marks the final one.
//   An item with a bad position or for a full list gives one result,
//   registered at the accepting edge, and busy stays low so the next item
//   may follow at once.
//   A valid item holds busy high through the shift, the insert and both
//   listing passes, so the next item is taken only after the tail-to-head
//   pass ends; the shift loop alternates store reads and writes, and the
//   listing reads one entry a cycle.
//   Reset (rst_n low, synchronous) empties the list; store contents are
//   not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_dump
  import pli_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [POS_W-1:0]  in_position,
  input  wire logic [DATA_W-1:0] in_value,
  output logic                   out_strobe,
  output logic [1:0]             out_status,
  output logic                   out_direction,
  output logic [DATA_W-1:0]      out_element,
  output logic                   out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pli_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  pli_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_position   (in_position),
    .in_value      (in_value),
    .cmd           (cmd),
    .stat          (stat),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_direction (out_direction),
    .out_element   (out_element),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire
